// ----- src/htfd_pkg.sv -----
// htfd_pkg: shared types, constants and the crc-8 byte update for the
// humidity / temperature reply decoder. No dependencies.
package htfd_pkg;

  // crc-8 over each word, x^8+x^5+x^4+1, no reflection, no final xor
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // conversion scales (hundredths) and the temperature offset
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [14:0] HUMID_SCALE = 15'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

  // raw word keeps its upper fourteen bits
  localparam logic [15:0] RAW_MASK = 16'hFFFC;

  // conversion request from the byte front end to the output stage
  typedef struct packed {
    logic        is_temp;   // temperature word (else humidity, ends the reply)
    logic        crc_ok;    // received crc matched the running crc
    logic [30:0] product;   // raw word times its scale
  } conv_req_t;

  // one byte through the crc, msb first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/htfd_front.sv -----
// htfd_front: byte position tracking, crc accumulation and word capture;
// on each crc byte it registers a scaled conversion request.
// Depends on htfd_pkg.
module htfd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  input  logic               hold,
  output logic               req_valid,
  output htfd_pkg::conv_req_t req
);
  import htfd_pkg::*;

  typedef enum logic [2:0] {
    POS_TEMP_HI,
    POS_TEMP_LO,
    POS_TEMP_CRC,
    POS_HUMID_HI,
    POS_HUMID_LO,
    POS_HUMID_CRC
  } pos_t;

  pos_t        byte_position;
  pos_t        byte_position_next;
  pos_t        pos_eff;
  logic [7:0]  running_crc;
  logic [7:0]  running_crc_next;
  logic [7:0]  word_high_byte;
  logic [7:0]  word_low_byte;
  logic        load_high;
  logic        load_low;
  logic        crc_byte;
  logic        accept;
  logic [15:0] raw;
  logic [14:0] scale;
  logic [30:0] product_next;

  // a request waiting on a blocked output stalls the whole front end
  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  // a start flag restarts the reply at its first byte
  assign pos_eff = frame_start ? POS_TEMP_HI : byte_position;

  // per-position update
  always_comb begin
    load_high          = 1'b0;
    load_low           = 1'b0;
    crc_byte           = 1'b0;
    running_crc_next   = running_crc;
    byte_position_next = byte_position;
    case (pos_eff)
      POS_TEMP_LO: begin
        running_crc_next   = crc8_feed(running_crc, rx_byte);
        load_low           = 1'b1;
        byte_position_next = POS_TEMP_CRC;
      end
      POS_TEMP_CRC: begin
        running_crc_next   = CRC_INIT;
        crc_byte           = 1'b1;
        byte_position_next = POS_HUMID_HI;
      end
      POS_HUMID_HI: begin
        running_crc_next   = crc8_feed(CRC_INIT, rx_byte);
        load_high          = 1'b1;
        byte_position_next = POS_HUMID_LO;
      end
      POS_HUMID_LO: begin
        running_crc_next   = crc8_feed(running_crc, rx_byte);
        load_low           = 1'b1;
        byte_position_next = POS_HUMID_CRC;
      end
      POS_HUMID_CRC: begin
        running_crc_next   = CRC_INIT;
        crc_byte           = 1'b1;
        byte_position_next = POS_TEMP_HI;
      end
      default: begin
        // first byte, also any position past the reply
        running_crc_next   = crc8_feed(CRC_INIT, rx_byte);
        load_high          = 1'b1;
        byte_position_next = POS_TEMP_LO;
      end
    endcase
  end

  // scaled raw word, the single multiplier of the block
  assign raw          = {word_high_byte, word_low_byte} & RAW_MASK;
  assign scale        = (pos_eff == POS_TEMP_CRC) ? TEMP_SCALE : HUMID_SCALE;
  assign product_next = {15'd0, raw} * {16'd0, scale};

  // reply state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= POS_TEMP_HI;
      running_crc    <= CRC_INIT;
      word_high_byte <= 8'd0;
      word_low_byte  <= 8'd0;
      req_valid      <= 1'b0;
    end else begin
      if (accept) begin
        byte_position <= byte_position_next;
        running_crc   <= running_crc_next;
        if (load_high) begin
          word_high_byte <= rx_byte;
        end
        if (load_low) begin
          word_low_byte <= rx_byte;
        end
      end
      if (!hold) begin
        req_valid <= accept && crc_byte;
      end
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (accept && crc_byte) begin
      req.is_temp <= (pos_eff == POS_TEMP_CRC);
      req.crc_ok  <= (running_crc == rx_byte);
      req.product <= product_next;
    end
  end

endmodule

// ----- src/humidity_temp_frame_decoder_unit.sv -----
// humidity_temp_frame_decoder_unit: top level of the reply decoder; divides
// the scaled words by 65535, keeps the last good values, drives the result.
// Depends on htfd_pkg and htfd_front.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | rx_byte, frame_start
//  out     | out_valid / out_stall| temp_centi, humid_centi, temp_crc_ok,
//          |                      | humid_crc_ok
//
// one byte request per cycle while in_stall is low; after the sixth byte the crc
// check and multiply are registered, then the divide by 65535 feeds the output register.
// synchronous reset clears the position, crc, held values and valid bits.
// in_stall rises only while a humidity request waits behind a stalled,
// full output register; until then bytes keep flowing.
module humidity_temp_frame_decoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] temp_centi,
  output logic [13:0]        humid_centi,
  output logic               temp_crc_ok,
  output logic               humid_crc_ok
);
  import htfd_pkg::*;

  conv_req_t          req;
  logic               req_valid;
  logic               hold;
  logic               drain;
  logic [31:0]        div_sum;
  logic [15:0]        quot;
  logic signed [15:0] temp_wide;
  logic signed [14:0] temp_q;
  logic [13:0]        humid_q;
  logic signed [14:0] held_temperature;
  logic [13:0]        held_humidity;
  logic               temp_ok_flag;

  htfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .frame_start(frame_start),
    .hold       (hold),
    .req_valid  (req_valid),
    .req        (req)
  );

  // only a reply-ending request waits for the output register
  assign hold  = req_valid && !req.is_temp && out_valid && out_stall;
  assign drain = req_valid && !hold;

  // floor(p / 65535) = (p + (p >> 16) + 1) >> 16 while the quotient is below 2^16
  assign div_sum   = {1'b0, req.product} + {17'd0, req.product[30:16]} + 32'd1;
  assign quot      = div_sum[31:16];
  assign temp_wide = $signed({1'b0, quot[14:0]}) - TEMP_OFFSET;
  assign temp_q    = temp_wide[14:0];
  assign humid_q   = quot[13:0];

  // held values and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      held_temperature <= '0;
      held_humidity    <= '0;
      temp_ok_flag     <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (drain && !req.is_temp) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (drain) begin
        if (req.is_temp) begin
          temp_ok_flag <= req.crc_ok;
          if (req.crc_ok) begin
            held_temperature <= temp_q;
          end
        end else begin
          if (req.crc_ok) begin
            held_humidity <= humid_q;
          end
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (drain && !req.is_temp) begin
      temp_centi   <= held_temperature;
      humid_centi  <= req.crc_ok ? humid_q : held_humidity;
      temp_crc_ok  <= temp_ok_flag;
      humid_crc_ok <= req.crc_ok;
    end
  end

endmodule

// ----- tb/humidity_temp_frame_decoder_unit_tb.sv -----
// humidity_temp_frame_decoder_unit_tb: self-checking bench for the reply decoder;
// byte requests in, checked readings out, with random idling on both sides.
// Depends on humidity_temp_frame_decoder_unit only.
module humidity_temp_frame_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected reading
  typedef struct {
    logic signed [14:0] temp;
    logic [13:0]        humid;
    logic               temp_ok;
    logic               humid_ok;
  } reading_t;

  // reply decoder prediction and comparison
  class reading_scoreboard;
    logic [2:0]         pos;
    logic [7:0]         crc;
    logic [7:0]         hi_byte;
    logic [7:0]         lo_byte;
    logic signed [14:0] temp_held;
    logic [13:0]        humid_held;
    logic               temp_match;
    reading_t           readings_due[$];
    int                 errors;
    int                 checked;
    int                 crc_misses;

    function new();
      pos = '0;
      crc = 8'hFF;
      hi_byte = '0;
      lo_byte = '0;
      temp_held = '0;
      humid_held = '0;
      temp_match = 1'b0;
      errors = 0;
      checked = 0;
      crc_misses = 0;
    endfunction

    // serial crc-8, poly x^8+x^5+x^4+1, msb first
    static function logic [7:0] crc_byte(logic [7:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ b[i];
        c = {c[6:0], 1'b0};
        if (fb) c = c ^ 8'h31;
      end
      return c;
    endfunction

    static function logic [7:0] word_crc(logic [15:0] w);
      return crc_byte(crc_byte(8'hFF, w[15:8]), w[7:0]);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // advance the predicted decoder by one accepted byte request
    function void note_byte(logic [7:0] b, logic start);
      logic [2:0]  p;
      int unsigned raw;
      int          conv;
      logic        match;
      reading_t    r;
      p = start ? 3'd0 : pos;
      if (p > 3'd5) p = 3'd0;
      raw = {16'h0, hi_byte, lo_byte} & 32'hFFFC;
      match = (crc == b);
      case (p)
        3'd0, 3'd3: begin
          crc = crc_byte(8'hFF, b);
          hi_byte = b;
          pos = p + 3'd1;
        end
        3'd1, 3'd4: begin
          crc = crc_byte(crc, b);
          lo_byte = b;
          pos = p + 3'd1;
        end
        3'd2: begin
          if (match) begin
            conv = (17500 * raw) / 65535;
            temp_held = 15'(conv - 4500);
          end else begin
            crc_misses++;
          end
          temp_match = match;
          crc = 8'hFF;
          pos = 3'd3;
        end
        default: begin
          if (match) begin
            conv = (10000 * raw) / 65535;
            humid_held = 14'(conv);
          end else begin
            crc_misses++;
          end
          crc = 8'hFF;
          pos = 3'd0;
          r.temp = temp_held;
          r.humid = humid_held;
          r.temp_ok = temp_match;
          r.humid_ok = match;
          readings_due.push_back(r);
        end
      endcase
    endfunction

    // compare one reading against the oldest one due
    task check_reading(logic signed [14:0] t, logic [13:0] h, logic tok, logic hok);
      reading_t r;
      if (readings_due.size() == 0) begin
        report_mismatch("reading arrived with none due");
      end else begin
        r = readings_due.pop_front();
        checked++;
        if (t !== r.temp)
          report_mismatch($sformatf("temp_centi %0d, want %0d", t, r.temp));
        if (h !== r.humid)
          report_mismatch($sformatf("humid_centi %0d, want %0d", h, r.humid));
        if (tok !== r.temp_ok)
          report_mismatch($sformatf("temp_crc_ok %b, want %b", tok, r.temp_ok));
        if (hok !== r.humid_ok)
          report_mismatch($sformatf("humid_crc_ok %b, want %b", hok, r.humid_ok));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = 8'h00;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] temp_centi;
  logic [13:0]        humid_centi;
  logic               temp_crc_ok;
  logic               humid_crc_ok;

  reading_scoreboard sb = new();
  logic              calm = 1'b0;
  int                bytes_sent = 0;

  humidity_temp_frame_decoder_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .temp_centi   (temp_centi),
    .humid_centi  (humid_centi),
    .temp_crc_ok  (temp_crc_ok),
    .humid_crc_ok (humid_crc_ok)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random output stall, none while calm
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 19);
  end

  // check every accepted reading
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_reading(temp_centi, humid_centi, temp_crc_ok, humid_crc_ok);
  end

  // hard stop if the run hangs
  initial begin
    #5ms;
    $display("timeout with %0d readings outstanding", sb.readings_due.size());
    $display("== FAIL ==");
    $finish;
  end

  // one byte request, held until accepted
  task automatic send_byte(input logic [7:0] b, input logic start);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    frame_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, start);
    bytes_sent++;
  endtask

  // full six-byte reply, optionally with corrupted crc bytes
  task automatic send_reply(input logic [15:0] t, input logic [15:0] h,
                            input bit t_good, input bit h_good, input logic flag);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = reading_scoreboard::word_crc(t);
    hc = reading_scoreboard::word_crc(h);
    if (!t_good) tc = tc ^ 8'($urandom_range(1, 255));
    if (!h_good) hc = hc ^ 8'($urandom_range(1, 255));
    send_byte(t[15:8], flag);
    send_byte(t[7:0], 1'b0);
    send_byte(tc, 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(hc, 1'b0);
  endtask

  // stop sending until every reading due has come out
  task automatic wait_drained();
    int n;
    n = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.readings_due.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
  endtask

  function automatic logic [15:0] pick_word();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'h0000;
    if (k == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  initial begin
    int k;
    int n;
    int target;
    bit drained_once;
    drained_once = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: no good reply yet, both crcs bad, held values read zero
    send_reply(16'hFFFF, 16'hFFFF, 0, 0, 1'b1);
    // top of scale, first byte without the start flag
    send_reply(16'hFFFF, 16'hFFFF, 1, 1, 1'b0);
    // partial reply abandoned by a start flag mid-reply
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    // bottom of scale with low bits set, humidity crc bad keeps old value
    send_reply(16'h0003, 16'h1234, 1, 0, 1'b1);
    wait_drained();

    // random: mostly well-formed replies, some broken ones and noise
    target = bytes_sent + 1800;
    while (bytes_sent < target) begin
      calm = (bytes_sent > target - 1300) && (bytes_sent < target - 1000);
      if (!drained_once && bytes_sent > target - 800) begin
        wait_drained();
        drained_once = 1;
      end
      k = $urandom_range(99);
      if (k < 75) begin
        send_reply(pick_word(), pick_word(), $urandom_range(9) < 8,
                   $urandom_range(9) < 8, $urandom_range(9) != 0);
      end else if (k < 87) begin
        n = $urandom_range(1, 5);
        send_byte(8'($urandom), 1'b1);
        for (int i = 1; i < n; i++) send_byte(8'($urandom), 1'b0);
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'($urandom));
      end
    end
    calm = 1'b0;

    // drain, then let the pipeline settle
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.readings_due.size() != 0)
      sb.report_mismatch($sformatf("%0d readings never arrived", sb.readings_due.size()));

    $display("sent %0d byte requests, checked %0d readings, %0d crc words rejected",
             bytes_sent, sb.checked, sb.crc_misses);
    $display("covered full replies, abandoned replies, bad crcs and random noise");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/htfd_pkg.sv
src/htfd_front.sv
src/humidity_temp_frame_decoder_unit.sv
tb/humidity_temp_frame_decoder_unit_tb.sv
